@@ hw/rtl/maa_pkg.sv @@
package maa_pkg;

  // fixed field widths
  localparam int NUM_IDX    = 4;
  localparam int IDX_SEL_W  = $clog2(NUM_IDX);
  localparam int IDX_W      = 12;
  localparam int BOUND_W    = 13;
  localparam int DIMS_W     = 3;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // parameter defaults
  localparam int MAX_DIMS_DEF    = 4;
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int ELEM_WIDTH_DEF  = 32;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOB = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAP = 2'd2;

  // command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_3  = 3'd4;

  // config reset values
  localparam logic [DIMS_W-1:0]  NUM_DIMS_RST = 3'd1;
  localparam logic [BOUND_W-1:0] BOUND_0_RST  = 13'd4096;
  localparam logic [BOUND_W-1:0] BOUND_N_RST  = 13'd1;

  typedef struct packed {
    logic [DIMS_W-1:0]               num_dims;
    logic [NUM_IDX-1:0][BOUND_W-1:0] bound;
  } cfg_t;

  typedef struct packed {
    logic                          cmd;
    logic [NUM_IDX-1:0][IDX_W-1:0] idx;
    logic [VAL_W-1:0]              wdata;
    logic                          oob;
  } item_t;

  // clamp the dimension count to 1..max_dims and to the number of subscript fields
  function automatic logic [DIMS_W-1:0] dims_in_use(input logic [DIMS_W-1:0] nd,
                                                    input int max_dims);
    logic [DIMS_W-1:0] n;
    n = (nd == '0) ? DIMS_W'(1) : nd;
    if (int'(n) > max_dims) n = DIMS_W'(max_dims);
    if (int'(n) > NUM_IDX) n = DIMS_W'(NUM_IDX);
    return n;
  endfunction

endpackage

@@ hw/rtl/maa_ram.sv @@
module maa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read, read data held until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hw/rtl/maa_front.sv @@
module maa_front #(
  parameter int MAX_DIMS = maa_pkg::MAX_DIMS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  maa_pkg::cfg_t                                   cfg,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic                                            in_cmd,
  input  logic [maa_pkg::NUM_IDX-1:0][maa_pkg::IDX_W-1:0] in_idx,
  input  logic [maa_pkg::VAL_W-1:0]                       in_wdata,
  output logic                                            q_valid,
  output maa_pkg::item_t                                  q_item,
  input  logic                                            q_pop
);

  localparam int QDEPTH = 2;

  logic [maa_pkg::DIMS_W-1:0] n_dims;
  logic                       oob;
  maa_pkg::item_t             push_item;
  maa_pkg::item_t             q_mem_r [QDEPTH];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 count_r, count_nxt;
  logic                       push;

  // bounds check on used dimensions
  always_comb begin
    n_dims = maa_pkg::dims_in_use(cfg.num_dims, MAX_DIMS);
    oob    = 1'b0;
    for (int d = 0; d < maa_pkg::NUM_IDX; d++) begin
      if ((d < int'(n_dims)) && ({1'b0, in_idx[d]} >= cfg.bound[d])) begin
        oob = 1'b1;
      end
    end
    push_item.cmd   = in_cmd;
    push_item.idx   = in_idx;
    push_item.wdata = in_wdata;
    push_item.oob   = oob;
  end

  // two-word queue toward the back end
  assign in_ready = (count_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/maa_back.sv @@
module maa_back #(
  parameter int MAX_DIMS    = maa_pkg::MAX_DIMS_DEF,
  parameter int STORE_DEPTH = maa_pkg::STORE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = maa_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  maa_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  maa_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [maa_pkg::VAL_W-1:0]     out_read_value,
  output logic [maa_pkg::STATUS_W-1:0]  out_status
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = AW + maa_pkg::BOUND_W + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_RD} state_t;

  state_t                          state_r, state_nxt;
  maa_pkg::item_t                  item_r, item_nxt;
  logic [AW-1:0]                   acc_r, acc_nxt;
  logic                            cap_r, cap_nxt;
  logic [maa_pkg::DIMS_W-1:0]      dim_r, dim_nxt;
  logic [maa_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [maa_pkg::VAL_W-1:0]       out_value_r, out_value_nxt;
  logic [maa_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic [maa_pkg::DIMS_W-1:0]      n_dims;
  logic [maa_pkg::IDX_SEL_W-1:0]   sel;
  logic [PW-1:0]                   first;
  logic [PW-1:0]                   sum;
  logic                            ram_en;
  logic [ELEM_WIDTH-1:0]           ram_wdata;
  logic [ELEM_WIDTH-1:0]           ram_rdata;
  logic [maa_pkg::VAL_W-1:0]       rd_ext;

  // element width adaptation
  generate
    if (ELEM_WIDTH >= maa_pkg::VAL_W) begin : g_wide
      assign ram_wdata = ELEM_WIDTH'(item_r.wdata);
      assign rd_ext    = ram_rdata[maa_pkg::VAL_W-1:0];
    end else begin : g_narrow
      assign ram_wdata = item_r.wdata[ELEM_WIDTH-1:0];
      assign rd_ext    = {{(maa_pkg::VAL_W-ELEM_WIDTH){ram_rdata[ELEM_WIDTH-1]}}, ram_rdata};
    end
  endgenerate

  maa_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (item_r.cmd == maa_pkg::CMD_WRITE),
    .addr  (acc_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // horner step: offset = offset * bound + index, one dimension a cycle
  always_comb begin
    n_dims = maa_pkg::dims_in_use(cfg.num_dims, MAX_DIMS);
    sel    = dim_r[maa_pkg::IDX_SEL_W-1:0];
    first  = PW'(q_item.idx[0]);
    sum    = PW'(acc_r) * PW'(cfg.bound[sel]) + PW'(item_r.idx[sel]);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    acc_nxt        = acc_r;
    cap_nxt        = cap_r;
    dim_nxt        = dim_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    ram_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          cap_nxt   = (first >= DEPTH_P);
          acc_nxt   = first[AW-1:0];
          dim_nxt   = maa_pkg::DIMS_W'(1);
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (dim_r < n_dims) begin
          if (!cap_r) begin
            if (sum >= DEPTH_P) begin
              cap_nxt = 1'b1;
            end else begin
              acc_nxt = sum[AW-1:0];
            end
          end
          dim_nxt = dim_r + maa_pkg::DIMS_W'(1);
        end else begin
          if (item_r.oob) begin
            status_nxt = maa_pkg::STATUS_OOB;
          end else if (cap_r) begin
            status_nxt = maa_pkg::STATUS_CAP;
          end else begin
            status_nxt = maa_pkg::STATUS_OK;
            ram_en     = 1'b1;
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = ((status_r == maa_pkg::STATUS_OK) &&
                            (item_r.cmd == maa_pkg::CMD_READ)) ? rd_ext : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r       <= item_nxt;
    acc_r        <= acc_nxt;
    cap_r        <= cap_nxt;
    dim_r        <= dim_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

@@ hw/rtl/multidim_array_access_top.sv @@
// the back end handles one word at a time: it pops a word from the queue, runs the
// single multiply-add unit over the dimensions in use (one dimension a cycle), makes
// one memory access and takes no new word until its result is in the output register
// the two-word input queue takes new words while the back end is busy
// reset (synchronous, rst_n low): num_dims = 1, bound_0 = 4096, other bounds = 1,
// queue and output empty; element store contents undefined until written
module multidim_array_access_top #(
  parameter int MAX_DIMS    = maa_pkg::MAX_DIMS_DEF,
  parameter int STORE_DEPTH = maa_pkg::STORE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = maa_pkg::ELEM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [maa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [maa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [maa_pkg::IDX_W-1:0]       in_index_0,
  input  logic [maa_pkg::IDX_W-1:0]       in_index_1,
  input  logic [maa_pkg::IDX_W-1:0]       in_index_2,
  input  logic [maa_pkg::IDX_W-1:0]       in_index_3,
  input  logic signed [maa_pkg::VAL_W-1:0] in_write_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [maa_pkg::VAL_W-1:0] out_read_value,
  output logic [maa_pkg::STATUS_W-1:0]    out_status
);

  maa_pkg::cfg_t                                   cfg_r, cfg_nxt;
  logic [maa_pkg::NUM_IDX-1:0][maa_pkg::IDX_W-1:0] in_idx;
  logic                                            q_valid;
  maa_pkg::item_t                                  q_item;
  logic                                            q_pop;
  logic [maa_pkg::VAL_W-1:0]                       rd_value;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        maa_pkg::CFG_NUM_DIMS: cfg_nxt.num_dims = cfg_data[maa_pkg::DIMS_W-1:0];
        maa_pkg::CFG_BOUND_0:  cfg_nxt.bound[0] = cfg_data;
        maa_pkg::CFG_BOUND_1:  cfg_nxt.bound[1] = cfg_data;
        maa_pkg::CFG_BOUND_2:  cfg_nxt.bound[2] = cfg_data;
        maa_pkg::CFG_BOUND_3:  cfg_nxt.bound[3] = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_dims <= maa_pkg::NUM_DIMS_RST;
      cfg_r.bound[0] <= maa_pkg::BOUND_0_RST;
      cfg_r.bound[1] <= maa_pkg::BOUND_N_RST;
      cfg_r.bound[2] <= maa_pkg::BOUND_N_RST;
      cfg_r.bound[3] <= maa_pkg::BOUND_N_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_idx = {in_index_3, in_index_2, in_index_1, in_index_0};

  // front end: bounds check and queue
  maa_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_idx   (in_idx),
    .in_wdata (in_write_value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back end: offset, capacity check, store access
  maa_back #(
    .MAX_DIMS    (MAX_DIMS),
    .STORE_DEPTH (STORE_DEPTH),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (rd_value),
    .out_status     (out_status)
  );

  assign out_read_value = rd_value;

  // checks
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == maa_pkg::STATUS_OK || out_status == maa_pkg::STATUS_OOB ||
                   out_status == maa_pkg::STATUS_CAP))
    else $error("illegal status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != maa_pkg::STATUS_OK) |-> (out_read_value == '0))
    else $error("error word carries nonzero data");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (!out_valid && in_ready))
    else $error("outputs not empty after reset");

endmodule

@@ tb/multidim_array_access_top_test.sv @@
`timescale 1ns / 1ps

module multidim_array_access_top_test;
  import maa_pkg::*;

  localparam int STORE_DEPTH = STORE_DEPTH_DEF;
  localparam int IDLE_PCT = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef logic [NUM_IDX-1:0][IDX_W-1:0] subs_t;

  // dimension count and bounds as the block sees them
  typedef struct packed {
    logic [DIMS_W-1:0]               dims;
    logic [NUM_IDX-1:0][BOUND_W-1:0] bound;
  } layout_t;

  typedef struct {
    logic                    cmd;
    subs_t                   idx;
    logic signed [VAL_W-1:0] wval;
  } access_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]     status;
  } reply_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  localparam layout_t LAYOUT_RESET =
    '{NUM_DIMS_RST, {BOUND_N_RST, BOUND_N_RST, BOUND_N_RST, BOUND_0_RST}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_READ;
  logic [IDX_W-1:0] in_index_0 = '0;
  logic [IDX_W-1:0] in_index_1 = '0;
  logic [IDX_W-1:0] in_index_2 = '0;
  logic [IDX_W-1:0] in_index_3 = '0;
  logic signed [VAL_W-1:0] in_write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_read_value;
  logic [STATUS_W-1:0] out_status;

  // stimulus side: layout being programmed and entries already written
  layout_t plan = LAYOUT_RESET;
  bit plan_written [STORE_DEPTH];
  longint unsigned written_offsets[$];

  // checking side: layout and array contents as accepted by the block
  layout_t live_layout = LAYOUT_RESET;
  logic signed [VAL_W-1:0] array_shadow [STORE_DEPTH];

  access_t access_queue[$];
  reg_write_t reg_writes[$];
  reply_t reply_queue[$];
  access_t next_access;
  reg_write_t next_reg;
  bit no_idle = 1'b0;
  int fail_count = 0;

  multidim_array_access_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_index_0(in_index_0), .in_index_1(in_index_1),
    .in_index_2(in_index_2), .in_index_3(in_index_3),
    .in_write_value(in_write_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // clamp the dimension count to 1..4
  function automatic int active_dims(layout_t c);
    if (c.dims == '0) return 1;
    if (c.dims > NUM_IDX) return NUM_IDX;
    return int'(c.dims);
  endfunction

  // row-major offset and status of one subscript set
  function automatic void locate_element(input layout_t c, input subs_t idx,
                                         output logic [STATUS_W-1:0] st,
                                         output longint unsigned off);
    longint unsigned stride;
    int n;
    n = active_dims(c);
    stride = 1;
    off = 0;
    st = STATUS_OK;
    for (int d = n - 1; d >= 0; d--) begin
      if (idx[d] >= c.bound[d]) st = STATUS_OOB;
      off += idx[d] * stride;
      stride *= c.bound[d];
    end
    if (st == STATUS_OK && off >= STORE_DEPTH) st = STATUS_CAP;
  endfunction

  function automatic layout_t apply_reg(layout_t c, logic [CFG_IDX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_NUM_DIMS: c.dims = data[DIMS_W-1:0];
      CFG_BOUND_0: c.bound[0] = data;
      CFG_BOUND_1: c.bound[1] = data;
      CFG_BOUND_2: c.bound[2] = data;
      CFG_BOUND_3: c.bound[3] = data;
      default: ;
    endcase
    return c;
  endfunction

  // subscripts that address a given offset, unused ones kept as passed
  function automatic subs_t split_offset(layout_t c, longint unsigned off, subs_t idx);
    int n;
    n = active_dims(c);
    for (int d = n - 1; d >= 0; d--) begin
      idx[d] = IDX_W'(off % c.bound[d]);
      off = off / c.bound[d];
    end
    return idx;
  endfunction

  function automatic subs_t subs(int i0, int i1, int i2, int i3);
    subs_t s;
    s[0] = IDX_W'(i0);
    s[1] = IDX_W'(i1);
    s[2] = IDX_W'(i2);
    s[3] = IDX_W'(i3);
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // queue one access; a read of a never-written entry becomes a write
  task automatic add_item(logic cmd, subs_t idx, logic [VAL_W-1:0] wval);
    logic [STATUS_W-1:0] st;
    longint unsigned off;
    access_t a;
    locate_element(plan, idx, st, off);
    if (st == STATUS_OK && cmd == CMD_READ && !plan_written[int'(off)]) cmd = CMD_WRITE;
    if (st == STATUS_OK && cmd == CMD_WRITE) begin
      plan_written[int'(off)] = 1'b1;
      written_offsets.push_back(off);
    end
    a.cmd = cmd;
    a.idx = idx;
    a.wval = wval;
    access_queue.push_back(a);
  endtask

  task automatic random_item();
    int mode;
    int n;
    int d;
    longint unsigned prod;
    longint unsigned span;
    longint unsigned off;
    longint unsigned pick;
    logic cmd;
    subs_t idx;
    n = active_dims(plan);
    prod = 1;
    for (int k = 0; k < n; k++) prod *= plan.bound[k];
    span = (prod > STORE_DEPTH) ? STORE_DEPTH : prod;
    mode = $urandom_range(0, 99);
    cmd = 1'($urandom_range(0, 1));
    for (int k = 0; k < NUM_IDX; k++) idx[k] = IDX_W'($urandom_range(0, 4095));
    if (mode < 60 && span != 0) begin
      // in-range access, often a revisit of an entry already written
      off = 64'($urandom_range(0, int'(span) - 1));
      if (mode >= 35 && written_offsets.size() != 0) begin
        pick = written_offsets[$urandom_range(0, written_offsets.size() - 1)];
        if (pick < span) begin
          off = pick;
          cmd = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_READ;
        end
      end
      idx = split_offset(plan, off, idx);
    end else if (mode < 80) begin
      // one subscript at or past its bound, if that bound is at most 4095
      if (span != 0) idx = split_offset(plan, 64'($urandom_range(0, int'(span) - 1)), idx);
      d = $urandom_range(0, n - 1);
      if (plan.bound[d] <= 4095) idx[d] = IDX_W'($urandom_range(int'(plan.bound[d]), 4095));
    end
    add_item(cmd, idx, rand_word());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data = data;
    reg_writes.push_back(w);
    plan = apply_reg(plan, index, data);
  endtask

  task automatic wait_idle();
    while (access_queue.size() != 0 || in_valid || reply_queue.size() != 0 ||
           reg_writes.size() != 0 || cfg_valid)
      @(negedge clk);
  endtask

  task automatic program_layout(logic [DIMS_W-1:0] nd, int b0, int b1, int b2, int b3);
    logic [CFG_DATA_W-DIMS_W-1:0] junk;
    junk = (CFG_DATA_W-DIMS_W)'($urandom);
    wait_idle();
    write_reg(CFG_NUM_DIMS, {junk, nd});
    write_reg(CFG_BOUND_0, CFG_DATA_W'(b0));
    write_reg(CFG_BOUND_1, CFG_DATA_W'(b1));
    write_reg(CFG_BOUND_2, CFG_DATA_W'(b2));
    write_reg(CFG_BOUND_3, CFG_DATA_W'(b3));
    wait_idle();
  endtask

  // random words, with one full drain halfway through
  task automatic random_items(int count);
    for (int i = 0; i < count / 2; i++) random_item();
    wait_idle();
    for (int i = count / 2; i < count; i++) random_item();
  endtask

  // configuration writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      live_layout = LAYOUT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) live_layout = apply_reg(live_layout, cfg_index, cfg_data);
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes.size() != 0) begin
          next_reg = reg_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_reg.index;
          cfg_data <= next_reg.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // expected reply for the word accepted at this edge
  task automatic predict_reply();
    logic [STATUS_W-1:0] st;
    longint unsigned off;
    reply_t r;
    locate_element(live_layout, {in_index_3, in_index_2, in_index_1, in_index_0}, st, off);
    r.status = st;
    r.read_value = '0;
    if (st == STATUS_OK) begin
      if (in_cmd == CMD_WRITE) array_shadow[int'(off)] = in_write_value;
      else r.read_value = array_shadow[int'(off)];
    end
    reply_queue.push_back(r);
  endtask

  // access driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_reply();
      if (!in_valid || in_ready) begin
        if (access_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_access = access_queue.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_access.cmd;
          in_index_0 <= next_access.idx[0];
          in_index_1 <= next_access.idx[1];
          in_index_2 <= next_access.idx[2];
          in_index_3 <= next_access.idx[3];
          in_write_value <= next_access.wval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    reply_t r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("reply with nothing expected");
        end else begin
          r = reply_queue.pop_front();
          if (out_status !== r.status)
            report_mismatch($sformatf("status got %0d expected %0d", out_status, r.status));
          if (out_read_value !== r.read_value)
            report_mismatch($sformatf("read_value got %0d expected %0d",
                                      out_read_value, r.read_value));
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset layout: one dimension of 4096, upper subscripts ignored
    add_item(CMD_WRITE, subs(0, 4095, 4095, 4095), 32'h8000_0000);
    add_item(CMD_WRITE, subs(4095, 0, 0, 0), 32'h7fff_ffff);
    add_item(CMD_READ, subs(0, 0, 0, 0), '0);
    add_item(CMD_READ, subs(4095, 4095, 4095, 4095), '0);
    add_item(CMD_WRITE, subs(1, 2048, 1, 2048), 32'hffff_ffff);
    add_item(CMD_READ, subs(1, 0, 4095, 0), '0);

    // four dimensions, 1024 elements
    program_layout(3'd4, 4, 8, 16, 2);
    add_item(CMD_WRITE, subs(3, 7, 15, 1), rand_word());
    add_item(CMD_READ, subs(3, 7, 15, 1), '0);
    add_item(CMD_WRITE, subs(4, 0, 0, 0), rand_word());
    add_item(CMD_READ, subs(0, 8, 0, 0), '0);
    add_item(CMD_WRITE, subs(0, 0, 16, 0), rand_word());
    add_item(CMD_READ, subs(0, 0, 0, 2), '0);
    random_items(130);

    // zero bound: everything out of bounds
    program_layout(3'd2, 5, 0, 3, 3);
    random_items(15);

    // 64 x 128 overflows the store
    program_layout(3'd2, 64, 128, 1, 1);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    wait_idle();
    add_item(CMD_WRITE, subs(63, 127, 0, 0), rand_word());
    add_item(CMD_READ, subs(32, 0, 0, 0), '0);
    random_items(120);

    // zero dimension count acts as one, bound above 4096, unused bounds junk
    program_layout(3'd0, 8191, $urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191));
    random_items(80);

    // count of seven acts as four, every bound at its maximum
    program_layout(3'd7, 8191, 8191, 8191, 8191);
    random_items(60);

    program_layout(3'd5, 16, 16, 16, 16);
    random_items(100);

    program_layout(3'd6, 1, 4096, 1, 3);
    random_items(60);

    // back-to-back traffic on both sides
    program_layout(3'd3, 1, 64, 64, 0);
    no_idle = 1'b1;
    random_items(85);

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/maa_pkg.sv
hw/rtl/maa_ram.sv
hw/rtl/maa_front.sv
hw/rtl/maa_back.sv
hw/rtl/multidim_array_access_top.sv
tb/multidim_array_access_top_test.sv
